/* rtl/u8u2_pkg.sv */
// Package for the UTF-8 to UCS-2 decoder: status codes, register indexes,
// result record and field widths. No dependencies.
package u8u2_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CAP_W  = 16;
    localparam int RCNT_W = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_CAPACITY   = 1'b0;
    localparam logic REG_COUNT_ONLY = 1'b1;

    // End-of-string status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // One result record
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_end;
        logic [RCNT_W-1:0] char_count;
        status_t           status;
    } result_t;

    // Configuration as seen by the decode stage
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             count_only;
    } cfg_t;

endpackage

/* rtl/utf8_to_ucs2_decoder.sv */
// Top level of the streaming UTF-8 to UCS-2 decoder.
// Depends on u8u2_pkg, u8u2_cfg_regs, u8u2_decode, u8u2_out_buf.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | in_valid/in_ready  | in_byte
//  output    | out_valid/out_ready| code_unit, is_end, char_count, status
//  config    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One byte is accepted per cycle while in_ready is high; its result, if any, is registered into the result buffer.
// The decode state is updated in the same cycle the byte is accepted.
// A two-entry result buffer lets input continue while one result waits;
// in_ready drops only when both entries are occupied.
// Reset clears decode state, configuration and the buffer at once.
module utf8_to_ucs2_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8u2_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8u2_pkg::UNIT_W-1:0]   code_unit,
    output logic                          is_end,
    output logic [u8u2_pkg::RCNT_W-1:0]   char_count,
    output logic [1:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8u2_pkg::ADDR_W-1:0]   paddr,
    input  logic [u8u2_pkg::DATA_W-1:0]   pwdata,
    output logic [u8u2_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import u8u2_pkg::*;

    cfg_t    cfg;
    result_t dec_res;
    result_t buf_res;
    logic    dec_valid;
    logic    in_fire;
    logic    buf_space;

    assign in_ready = buf_space;
    assign in_fire  = in_valid & buf_space;

    // Configuration registers
    u8u2_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Byte decode
    u8u2_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (in_byte),
        .cfg       (cfg),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    // Result buffer
    u8u2_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dec_valid),
        .push_data (dec_res),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (buf_res)
    );

    assign code_unit  = buf_res.code_unit;
    assign is_end     = buf_res.is_end;
    assign char_count = buf_res.char_count;
    assign status     = buf_res.status;

endmodule

/* rtl/u8u2_cfg_regs.sv */
// Configuration registers of the UTF-8 to UCS-2 decoder behind an APB-style port.
// Depends on u8u2_pkg.
module u8u2_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8u2_pkg::ADDR_W-1:0]   paddr,
    input  logic [u8u2_pkg::DATA_W-1:0]   pwdata,
    output logic [u8u2_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output u8u2_pkg::cfg_t                cfg
);
    import u8u2_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             count_only_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= '0;
            count_only_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CAPACITY:   capacity_reg   <= pwdata[CAP_W-1:0];
                REG_COUNT_ONLY: count_only_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (reg_sel)
            REG_CAPACITY:   prdata = {{(DATA_W-CAP_W){1'b0}}, capacity_reg};
            REG_COUNT_ONLY: prdata = {{(DATA_W-1){1'b0}}, count_only_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.capacity   = capacity_reg;
    assign cfg.count_only = count_only_reg;

endmodule

/* rtl/u8u2_decode.sv */
// Decode stage: per-string state registers and the one-byte step logic.
// Depends on u8u2_pkg.
module u8u2_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [u8u2_pkg::BYTE_W-1:0]   in_byte,
    input  u8u2_pkg::cfg_t                cfg,
    output logic                          res_valid,
    output u8u2_pkg::result_t             res
);
    import u8u2_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    logic [1:0]            pending_reg, pending_next;
    logic [UNIT_W-1:0]     acc_reg, acc_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    status_t               stop_reg, stop_next;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      cnt_inc_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic [RCNT_W-1:0]     cnt_report;
    status_t               end_status;

    // Saturating increment and widened compare operands
    assign cnt_inc     = (cnt_reg == {COUNT_BITS{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_ext     = CMP_W'(cnt_reg);
    assign cnt_inc_ext = CMP_W'(cnt_inc);
    assign cap_ext     = CMP_W'(cfg.capacity);
    assign cnt_report  = (cnt_ext > CMP_W'({RCNT_W{1'b1}})) ? {RCNT_W{1'b1}}
                                                             : cnt_ext[RCNT_W-1:0];
    assign end_status  = (stop_reg == ST_OK && pending_reg != 2'd0) ? ST_INVALID : stop_reg;

    // Step logic for one accepted byte
    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        stop_next    = stop_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (in_fire)
        begin
            if (in_byte == '0)
            begin
                // terminator: report and clear
                res_valid      = 1'b1;
                res.is_end     = 1'b1;
                res.char_count = cnt_report;
                res.status     = end_status;
                pending_next   = 2'd0;
                acc_next       = '0;
                cnt_next       = '0;
                stop_next      = ST_OK;
            end
            else if (stop_reg != ST_OK)
            begin
                // stopped: ignore until terminator
            end
            else if (pending_reg != 2'd0)
            begin
                // continuation byte
                if (in_byte[7:6] != 2'b10)
                begin
                    stop_next = ST_INVALID;
                end
                else
                begin
                    acc_next     = {acc_reg[UNIT_W-7:0], in_byte[5:0]};
                    pending_next = pending_reg - 2'd1;
                    if (pending_reg == 2'd1)
                    begin
                        if (cfg.count_only)
                        begin
                            cnt_next = cnt_inc;
                        end
                        else
                        begin
                            res_valid     = 1'b1;
                            res.code_unit = {acc_reg[UNIT_W-7:0], in_byte[5:0]};
                        end
                    end
                end
            end
            else if (!cfg.count_only && cnt_inc_ext >= cap_ext)
            begin
                // lead byte over capacity
                cnt_next  = cnt_inc;
                stop_next = ST_TRUNC;
            end
            else
            begin
                // lead byte, or invalid byte that stops the string
                if (!cfg.count_only)
                begin
                    cnt_next = cnt_inc;
                end
                if (in_byte[7] == 1'b0)
                begin
                    if (cfg.count_only)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.code_unit = UNIT_W'(in_byte);
                    end
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    acc_next     = UNIT_W'(in_byte[4:0]);
                    pending_next = 2'd1;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    acc_next     = UNIT_W'(in_byte[3:0]);
                    pending_next = 2'd2;
                end
                else
                begin
                    stop_next = ST_INVALID;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            stop_reg    <= ST_OK;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
        end
    end

endmodule

/* rtl/u8u2_out_buf.sv */
// Two-entry result buffer between the decode stage and the output channel.
// Depends on u8u2_pkg.
module u8u2_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u8u2_pkg::result_t  push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output u8u2_pkg::result_t  out_data
);
    import u8u2_pkg::*;

    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] fill_reg, fill_next;
    logic       pop;

    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = head_reg;
    assign space     = (fill_reg != 2'd2);
    assign pop       = out_valid & out_ready;

    // Buffer update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push && pop)
        begin
            if (fill_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (push)
        begin
            if (fill_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
            fill_next = fill_reg + 2'd1;
        end
        else if (pop)
        begin
            head_next = tail_reg;
            fill_next = fill_reg - 2'd1;
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
